// File: rtl/trsd_pkg.sv
// Shared types and constants of the text run-length span decoder.
package trsd_pkg;

   typedef logic [1:0]  action_type;
   typedef logic [1:0]  status_type;
   typedef logic [7:0]  byte_type;
   typedef logic [15:0] word_type;

   localparam action_type ACT_DATA   = 2'd0;
   localparam action_type ACT_EOF    = 2'd1;
   localparam action_type ACT_NEW    = 2'd2;

   localparam status_type ST_RUNNING   = 2'd0;
   localparam status_type ST_BAD_SIG   = 2'd1;
   localparam status_type ST_FINISHED  = 2'd2;
   localparam status_type ST_MALFORMED = 2'd3;

   localparam int unsigned LINE_PITCH       = 320;
   localparam int unsigned TRANSPARENT_CODE = 255;

   localparam byte_type SEP_CONTINUE = 8'h5E;  // '^'
   localparam byte_type SEP_LINE_END = 8'h21;  // '!'
   localparam byte_type CHAR_ZERO    = 8'h30;
   localparam byte_type CHAR_NINE    = 8'h39;
   localparam byte_type CHAR_SPACE   = 8'h20;
   localparam byte_type CHAR_TAB     = 8'h09;
   localparam byte_type CHAR_CR      = 8'h0D;

   localparam logic [1:0] CSR_START_X      = 2'd0;
   localparam logic [1:0] CSR_START_Y      = 2'd1;
   localparam logic [1:0] CSR_COLOR_OFFSET = 2'd2;

   typedef struct packed {
      logic       draw;
      word_type   address;
      word_type   length;
      byte_type   color;
      logic       line_end;
      status_type status;
   } span_type;

   // signature byte at each header position
   function automatic byte_type sig_byte(input logic [1:0] idx);
      byte_type b;
      case (idx)
         2'd0:    b = 8'h42;
         2'd1:    b = 8'h47;
         2'd2:    b = 8'h46;
         default: b = 8'h5F;
      endcase
      return b;
   endfunction

endpackage

// File: rtl/trsd_req_if.sv
// Input byte channel of the span decoder.
interface trsd_req_if
   import trsd_pkg::*;
   ();
   logic       valid;
   logic       ready;
   action_type action;
   byte_type   data_byte;

   modport source (output valid, action, data_byte, input ready);
   modport sink   (input valid, action, data_byte, output ready);
endinterface

// File: rtl/trsd_rsp_if.sv
// Span result channel of the span decoder.
interface trsd_rsp_if
   import trsd_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic       draw;
   word_type   address;
   word_type   length;
   byte_type   color;
   logic       line_end;
   status_type status;

   modport source (output valid, draw, address, length, color, line_end, status,
                   input ready);
   modport sink   (input valid, draw, address, length, color, line_end, status,
                   output ready);
endinterface

// File: rtl/text_rle_span_decoder_unit.sv
// Top level of the text run-length span decoder.
//
// Usage: file bytes enter on req_ch (action 0 with data_byte, 1 end of file,
// 2 start a new image). Each byte is parsed in the cycle it transfers; a run
// that completes, a signature mismatch, a malformed count or an end of file
// yields one span result on rsp_ch. The span carries the frame address
// (row * LINE_PITCH + column, 16 bits), length, colour and status; pixel
// fill is up to the consumer.
// Results land in the output register, or in the skid buffer while rsp_ch
// stalls. Throughput: one byte per cycle while req_ch.ready is high, set by
// the single parse step between the input transfer and the result register.
// Stalls: results sit in an output register backed by a one-entry skid
// buffer. req_ch.ready drops only while the skid holds a result: while rsp_ch
// stalls, bytes that yield no result keep transferring, one more result lands
// in the skid, and then input holds until the skid drains.
// Reset: parser returns to the signature check, position and run state
// clear, registers start_x/start_y/color_offset clear, no result pending.
// csr_* writes are taken at any clock and meant for idle periods only.
module text_rle_span_decoder_unit
   import trsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   trsd_req_if.sink    req_ch,
   trsd_rsp_if.source  rsp_ch,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_COUNT  = 4'b0010,
      PH_COLOR  = 4'b0100,
      PH_IDLE   = 4'b1000
   } phase_type;

   // configuration
   logic [8:0] start_x_ff;
   logic [7:0] start_y_ff;
   byte_type   color_offset_ff;

   // parser state; row_base_ff holds row * LINE_PITCH mod 2^16
   phase_type  phase_ff, phase_in;
   logic [1:0] header_index_ff, header_index_in;
   word_type   run_count_ff, run_count_in;
   logic       seen_digit_ff, seen_digit_in;
   byte_type   separator_ff, separator_in;
   word_type   column_pos_ff, column_pos_in;
   word_type   row_base_ff, row_base_in;

   // result path
   logic       out_valid_ff, skid_valid_ff;
   span_type   out_ff, skid_ff;
   logic       push;
   span_type   result;

   logic       accept, out_free;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !skid_valid_ff;
   assign out_free     = !out_valid_ff || rsp_ch.ready;

   // one parse step per transferred byte
   always_comb begin
      byte_type   b;
      logic       is_digit, is_space, transparent;
      logic [19:0] scaled;
      b           = req_ch.data_byte;
      is_digit    = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      is_space    = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
      transparent = (b == byte_type'(TRANSPARENT_CODE));
      scaled      = {1'b0, run_count_ff, 3'b000} + {3'b000, run_count_ff, 1'b0}
                    + {16'd0, b[3:0]};

      phase_in        = phase_ff;
      header_index_in = header_index_ff;
      run_count_in    = run_count_ff;
      seen_digit_in   = seen_digit_ff;
      separator_in    = separator_ff;
      column_pos_in   = column_pos_ff;
      row_base_in     = row_base_ff;
      push            = 1'b0;
      result          = '0;

      if (req_ch.action == ACT_NEW) begin
         phase_in        = PH_HEADER;
         header_index_in = 2'd0;
         run_count_in    = '0;
         seen_digit_in   = 1'b0;
         separator_in    = '0;
      end else if (req_ch.action == ACT_EOF) begin
         if (phase_ff != PH_IDLE) begin
            push          = 1'b1;
            result.status = (phase_ff == PH_HEADER) ? ST_BAD_SIG : ST_FINISHED;
            phase_in      = PH_IDLE;
         end
      end else if (req_ch.action == ACT_DATA) begin
         case (phase_ff)
            PH_HEADER: begin
               if (b != sig_byte(header_index_ff)) begin
                  push          = 1'b1;
                  result.status = ST_BAD_SIG;
                  phase_in      = PH_IDLE;
               end else if (header_index_ff == 2'd3) begin
                  phase_in        = PH_COUNT;
                  header_index_in = 2'd0;
                  run_count_in    = '0;
                  seen_digit_in   = 1'b0;
                  column_pos_in   = {7'd0, start_x_ff};
                  row_base_in     = word_type'({8'd0, start_y_ff} * word_type'(LINE_PITCH));
               end else begin
                  header_index_in = header_index_ff + 2'd1;
               end
            end
            PH_COUNT: begin
               if (is_digit) begin
                  // saturate at the top of the 16-bit range
                  run_count_in  = (scaled[19:16] != 4'd0) ? 16'hFFFF : scaled[15:0];
                  seen_digit_in = 1'b1;
               end else if (seen_digit_ff) begin
                  separator_in = b;
                  phase_in     = PH_COLOR;
               end else if (!is_space) begin
                  push          = 1'b1;
                  result.status = ST_MALFORMED;
                  phase_in      = PH_IDLE;
               end
            end
            PH_COLOR: begin
               push            = 1'b1;
               result.address  = row_base_ff + column_pos_ff;
               result.length   = run_count_ff;
               result.color    = transparent ? 8'd0 : b + color_offset_ff;
               result.draw     = !transparent && (run_count_ff != 16'd0);
               column_pos_in   = column_pos_ff + run_count_ff;
               run_count_in    = '0;
               seen_digit_in   = 1'b0;
               if (separator_ff == SEP_CONTINUE) begin
                  phase_in = PH_COUNT;
               end else if (separator_ff == SEP_LINE_END) begin
                  result.line_end = 1'b1;
                  row_base_in     = row_base_ff + word_type'(LINE_PITCH);
                  column_pos_in   = {7'd0, start_x_ff};
                  phase_in        = PH_COUNT;
               end else begin
                  result.status = ST_FINISHED;
                  phase_in      = PH_IDLE;
               end
            end
            default: begin
               // idle: drop data bytes
            end
         endcase
      end
   end

   // configuration writes; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff      <= '0;
         start_y_ff      <= '0;
         color_offset_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_START_X:      start_x_ff      <= csr_data;
            CSR_START_Y:      start_y_ff      <= csr_data[7:0];
            CSR_COLOR_OFFSET: color_offset_ff <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // parser state advances only on a transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_index_ff <= '0;
         run_count_ff    <= '0;
         seen_digit_ff   <= 1'b0;
         separator_ff    <= '0;
         column_pos_ff   <= '0;
         row_base_ff     <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         header_index_ff <= header_index_in;
         run_count_ff    <= run_count_in;
         seen_digit_ff   <= seen_digit_in;
         separator_ff    <= separator_in;
         column_pos_ff   <= column_pos_in;
         row_base_ff     <= row_base_in;
      end
   end

   // output register with skid: the skid fills only when the output is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= accept && push;
         end else begin
            out_valid_ff  <= accept && push;
         end
      end else if (accept && push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff  <= skid_ff;
            skid_ff <= result;
         end else begin
            out_ff  <= result;
         end
      end else if (accept && push) begin
         skid_ff <= result;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.draw     = out_ff.draw;
   assign rsp_ch.address  = out_ff.address;
   assign rsp_ch.length   = out_ff.length;
   assign rsp_ch.color    = out_ff.color;
   assign rsp_ch.line_end = out_ff.line_end;
   assign rsp_ch.status   = out_ff.status;

endmodule

// File: tb/trsd_span_checker.sv
// Span checker: predicts decoder spans from observed byte transfers and compares results.
`timescale 1ns / 100ps

module trsd_span_checker
   import trsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   trsd_req_if         req_mon,
   trsd_rsp_if         rsp_mon,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data,
   output int unsigned mismatches,
   output int unsigned open_spans
);

   typedef enum logic [1:0] {
      PARSE_HEADER,
      PARSE_COUNT,
      PARSE_COLOR,
      PARSE_IDLE
   } parse_phase_type;

   // file magic, first byte in the top lane
   localparam logic [31:0] FILE_MAGIC = 32'h4247_465F;

   logic [8:0]   origin_x;
   logic [7:0]   origin_y;
   logic [7:0]   tint;

   parse_phase_type parse;
   logic [1:0]   magic_pos;
   word_type     count_acc;
   logic         have_digit;
   byte_type     sep_byte;
   word_type     column;
   word_type     row;

   span_type     spans_due[$];

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Advance the parser by one transfer; return 1 when it yields a span.
   function automatic bit parse_byte(input action_type act, input byte_type b,
                                     output span_type span);
      logic [31:0] grown;
      logic [31:0] where_at;
      span = '0;
      if (act == ACT_NEW) begin
         parse      = PARSE_HEADER;
         magic_pos  = '0;
         count_acc  = '0;
         have_digit = 1'b0;
         sep_byte   = '0;
         return 1'b0;
      end
      if (parse == PARSE_IDLE || (act != ACT_DATA && act != ACT_EOF))
         return 1'b0;
      if (act == ACT_EOF) begin
         span.status = (parse == PARSE_HEADER) ? ST_BAD_SIG : ST_FINISHED;
         parse = PARSE_IDLE;
         return 1'b1;
      end
      case (parse)
         PARSE_HEADER: begin
            if (b != FILE_MAGIC[8 * (3 - magic_pos) +: 8]) begin
               span.status = ST_BAD_SIG;
               parse = PARSE_IDLE;
               return 1'b1;
            end
            if (magic_pos == 2'd3) begin
               parse      = PARSE_COUNT;
               magic_pos  = '0;
               count_acc  = '0;
               have_digit = 1'b0;
               column     = word_type'(origin_x);
               row        = word_type'(origin_y);
            end else begin
               magic_pos++;
            end
            return 1'b0;
         end
         PARSE_COUNT: begin
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               grown = 32'(count_acc) * 32'd10 + 32'(b - CHAR_ZERO);
               count_acc  = (grown > 32'hFFFF) ? 16'hFFFF : grown[15:0];
               have_digit = 1'b1;
               return 1'b0;
            end
            if (have_digit) begin
               sep_byte = b;
               parse    = PARSE_COLOR;
               return 1'b0;
            end
            if (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR))
               return 1'b0;
            span.status = ST_MALFORMED;
            parse = PARSE_IDLE;
            return 1'b1;
         end
         default: begin
            where_at     = 32'(row) * LINE_PITCH + 32'(column);
            span.address = where_at[15:0];
            span.length  = count_acc;
            if (b == TRANSPARENT_CODE) begin
               span.color = '0;
               span.draw  = 1'b0;
            end else begin
               span.color = b + tint;
               span.draw  = (count_acc != 0);
            end
            column = column + count_acc;
            if (sep_byte == SEP_CONTINUE) begin
               parse = PARSE_COUNT;
            end else if (sep_byte == SEP_LINE_END) begin
               span.line_end = 1'b1;
               row    = row + 16'd1;
               column = word_type'(origin_x);
               parse  = PARSE_COUNT;
            end else begin
               span.status = ST_FINISHED;
               parse = PARSE_IDLE;
            end
            count_acc  = '0;
            have_digit = 1'b0;
            return 1'b1;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      span_type want;
      span_type guess;
      if (reset) begin
         origin_x   = '0;
         origin_y   = '0;
         tint       = '0;
         parse      = PARSE_HEADER;
         magic_pos  = '0;
         count_acc  = '0;
         have_digit = 1'b0;
         sep_byte   = '0;
         column     = '0;
         row        = '0;
         mismatches = 0;
         spans_due.delete();
      end else begin
         // a result at this edge comes from an earlier byte: compare first
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (spans_due.size() == 0) begin
               $error("span with no expectation pending: status %0d", rsp_mon.status);
               mismatches++;
            end else begin
               want = spans_due.pop_front();
               check_field("draw", want.draw, rsp_mon.draw);
               check_field("address", want.address, rsp_mon.address);
               check_field("length", want.length, rsp_mon.length);
               check_field("color", want.color, rsp_mon.color);
               check_field("line_end", want.line_end, rsp_mon.line_end);
               check_field("status", want.status, rsp_mon.status);
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_START_X:      origin_x = csr_data;
               CSR_START_Y:      origin_y = csr_data[7:0];
               CSR_COLOR_OFFSET: tint     = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (parse_byte(req_mon.action, req_mon.data_byte, guess))
               spans_due.push_back(guess);
         end
      end
      open_spans <= spans_due.size();
   end

endmodule

// File: tb/tb_top.sv
// Top of the span decoder testbench: clock, reset, byte stimulus, result stalls and verdict.
`timescale 1ns / 100ps

module tb_top;
   import trsd_pkg::*;

   // action code the decoder must ignore
   localparam action_type  ACT_RESERVED = 2'd3;
   localparam byte_type    CHAR_PLUS    = 8'h2B;
   localparam byte_type    CHAR_MINUS   = 8'h2D;
   localparam int unsigned RANDOM_ITEMS = 1550;
   localparam int unsigned PHASES       = 8;
   // far above the longest legal quiet stretch
   localparam int unsigned QUIET_LIMIT  = 2000;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [8:0]  csr_data;
   int unsigned mismatches;
   int unsigned open_spans;

   int unsigned items_sent = 0;
   int          burst_left = 0;
   // when set, both sides run without gaps or stalls
   bit          steady = 1'b0;

   trsd_req_if req_ch ();
   trsd_rsp_if rsp_ch ();

   text_rle_span_decoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   trsd_span_checker span_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .open_spans (open_spans)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Offer one byte and hold it until the decoder takes it. Bursts of random
   // length are separated by random gaps; only counted bytes advance the
   // stimulus budget (most bytes the decoder ignores are sent uncounted).
   task automatic push_byte(input action_type act, input byte_type value, input bit counted);
      int gap;
      if (burst_left == 0) begin
         gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.action    <= act;
      req_ch.data_byte <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (counted) items_sent++;
   endtask

   // Send the first n bytes of the file magic.
   task automatic send_header(input int n);
      for (int i = 0; i < n; i++) push_byte(ACT_DATA, sig_byte(2'(i)), 1'b1);
   endtask

   // Send a count as decimal text, most significant digit first.
   task automatic send_count(input int unsigned value, input int zeros);
      byte_type    digits[10];
      int          n;
      int unsigned rest;
      n = 0;
      rest = value;
      do begin
         digits[n] = CHAR_ZERO + byte_type'(rest % 10);
         rest = rest / 10;
         n++;
      end while (rest != 0);
      repeat (zeros) push_byte(ACT_DATA, CHAR_ZERO, 1'b1);
      for (int i = n - 1; i >= 0; i--) push_byte(ACT_DATA, digits[i], 1'b1);
   endtask

   // One complete run: optional whitespace and leading zeros, count,
   // separator, colour. Occasionally slip in an ignored action.
   task automatic send_run(input int unsigned count, input byte_type sep, input byte_type paint);
      byte_type ws;
      int       spaces;
      spaces = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (spaces) begin
         ws = $urandom_range(0, 1) ? CHAR_SPACE : byte_type'($urandom_range(CHAR_TAB, CHAR_CR));
         push_byte(ACT_DATA, ws, 1'b1);
      end
      send_count(count, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
      if ($urandom_range(0, 29) == 0) push_byte(ACT_RESERVED, byte_type'($urandom), 1'b0);
      push_byte(ACT_DATA, sep, 1'b1);
      push_byte(ACT_DATA, paint, 1'b1);
   endtask

   // Mostly short counts; some long ones and a few past the saturation point.
   function automatic int unsigned pick_count();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return $urandom_range(0, 20);
      if (pick < 85) return $urandom_range(0, 400);
      if (pick < 95) return $urandom_range(0, 65535);
      return $urandom_range(65536, 32'd4000000000);
   endfunction

   // Write all three registers on consecutive edges, then drop the enable.
   task automatic set_config(input logic [8:0] x, input logic [8:0] y, input logic [8:0] offset);
      csr_write <= 1'b1;
      csr_index <= CSR_START_X;
      csr_data  <= x;
      @(posedge clock);
      csr_index <= CSR_START_Y;
      csr_data  <= y;
      @(posedge clock);
      csr_index <= CSR_COLOR_OFFSET;
      csr_data  <= offset;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Stop offering bytes, wait for every predicted span, then let the
   // pipeline settle so a byte that yields nothing is fully absorbed.
   task automatic drain(input int extra);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (open_spans != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // Result-side stall pattern: long ready stretches, short and long stalls,
   // and cycle-by-cycle toggling.
   initial begin
      int hold;
      int pick;
      bit level;
      hold = 0;
      level = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold == 0) begin
            pick = $urandom_range(0, 9);
            if (steady) begin
               level = 1'b1;
               hold  = 1;
            end else if (pick < 5) begin
               level = 1'b1;
               hold  = $urandom_range(1, 20);
            end else if (pick < 8) begin
               level = 1'b0;
               hold  = $urandom_range(1, 4);
            end else if (pick == 8) begin
               level = 1'b0;
               hold  = $urandom_range(10, 30);
            end else begin
               level = $urandom_range(0, 1);
               hold  = 1;
            end
         end
         rsp_ch.ready <= level;
         hold--;
      end
   end

   // Watchdog: end the run when nothing transfers on either channel for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int          kind;
      int          ending;
      int          runs;
      int          n;
      int unsigned target;
      byte_type    sep;
      byte_type    odd;
      byte_type    paint;

      reset            <= 1'b1;
      csr_write        <= 1'b0;
      csr_index        <= CSR_START_X;
      csr_data         <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.action    <= ACT_DATA;
      req_ch.data_byte <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with start_x 319, start_y 199 and colour offset 255.
      set_config(9'd319, 9'd199, 9'd255);
      send_header(4);
      // zero-length run; colour 0 plus the offset
      push_byte(ACT_DATA, CHAR_ZERO, 1'b1);
      push_byte(ACT_DATA, SEP_CONTINUE, 1'b1);
      push_byte(ACT_DATA, 8'h00, 1'b1);
      // whitespace before the count, count that saturates, line end, transparent colour
      push_byte(ACT_DATA, CHAR_CR, 1'b1);
      send_count(70000, 0);
      push_byte(ACT_DATA, SEP_LINE_END, 1'b1);
      push_byte(ACT_DATA, byte_type'(TRANSPARENT_CODE), 1'b1);
      // signed count: malformed, decoder goes idle
      push_byte(ACT_DATA, CHAR_MINUS, 1'b1);
      // reserved action, data and end of file while idle: all ignored
      push_byte(ACT_RESERVED, 8'hA5, 1'b0);
      push_byte(ACT_DATA, 8'h31, 1'b0);
      push_byte(ACT_EOF, 8'h00, 1'b0);
      // end of file in the middle of a count
      push_byte(ACT_NEW, 8'h00, 1'b1);
      send_header(4);
      push_byte(ACT_DATA, CHAR_ZERO + 8'd3, 1'b1);
      push_byte(ACT_EOF, 8'hFF, 1'b1);
      // magic mismatch on the second byte
      push_byte(ACT_NEW, 8'hFF, 1'b1);
      send_header(1);
      push_byte(ACT_DATA, ~sig_byte(2'd1), 1'b1);
      // end of file during the magic check
      push_byte(ACT_NEW, 8'h5A, 1'b1);
      push_byte(ACT_EOF, 8'h00, 1'b1);

      // Random part: several register settings, extremes first.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain(3);
         case (phase)
            0:       set_config(9'd0, 9'd0, 9'd0);
            1:       set_config(9'd319, 9'd199, 9'd255);
            default: set_config(9'($urandom_range(0, 319)), 9'($urandom_range(0, 199)),
                                9'($urandom_range(0, 255)));
         endcase
         steady = (phase % 3 == 2);
         target = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < target) begin
            kind = $urandom_range(0, 99);
            push_byte(ACT_NEW, byte_type'($urandom), 1'b1);
            if (kind < 72) begin
               // well-formed file with random runs and a random ending
               send_header(4);
               runs   = $urandom_range(1, 14);
               ending = $urandom_range(0, 9);
               for (int r = 0; r < runs; r++) begin
                  if (r == runs - 1 && ending < 4) begin
                     // any other separator closes the image
                     do odd = byte_type'($urandom);
                     while ((odd >= CHAR_ZERO && odd <= CHAR_NINE) ||
                            odd == SEP_CONTINUE || odd == SEP_LINE_END);
                     sep = odd;
                  end else begin
                     sep = ($urandom_range(0, 99) < 65) ? SEP_CONTINUE : SEP_LINE_END;
                  end
                  paint = ($urandom_range(0, 3) == 0) ? byte_type'(TRANSPARENT_CODE)
                                                      : byte_type'($urandom);
                  send_run(pick_count(), sep, paint);
               end
               case (ending)
                  0, 1, 2, 3: begin
                     // trailing bytes after the image closed are ignored
                     if ($urandom_range(0, 3) == 0) begin
                        push_byte(ACT_DATA, byte_type'($urandom), 1'b0);
                        push_byte(ACT_EOF, byte_type'($urandom), 1'b0);
                     end
                  end
                  4, 5: push_byte(ACT_EOF, byte_type'($urandom), 1'b1);
                  6: begin
                     // drop a partial count at end of file
                     send_count(pick_count(), 0);
                     push_byte(ACT_EOF, byte_type'($urandom), 1'b1);
                  end
                  7: begin
                     // end of file while waiting for the colour
                     send_count(pick_count(), 0);
                     push_byte(ACT_DATA, SEP_CONTINUE, 1'b1);
                     push_byte(ACT_EOF, byte_type'($urandom), 1'b1);
                  end
                  8: begin
                     // sign or other junk where a count belongs
                     case ($urandom_range(0, 2))
                        0:       odd = CHAR_PLUS;
                        1:       odd = CHAR_MINUS;
                        default: begin
                           do odd = byte_type'($urandom);
                           while ((odd >= CHAR_ZERO && odd <= CHAR_NINE) || odd == CHAR_SPACE ||
                                  (odd >= CHAR_TAB && odd <= CHAR_CR));
                        end
                     endcase
                     push_byte(ACT_DATA, odd, 1'b1);
                  end
                  default: send_count(pick_count(), 0);  // abandoned; next file restarts
               endcase
            end else if (kind < 82) begin
               // magic mismatch at a random position
               n = $urandom_range(0, 3);
               send_header(n);
               do odd = byte_type'($urandom); while (odd == sig_byte(2'(n)));
               push_byte(ACT_DATA, odd, 1'b1);
            end else if (kind < 88) begin
               send_header($urandom_range(0, 3));
               push_byte(ACT_EOF, byte_type'($urandom), 1'b1);
            end else begin
               // noise: random actions and bytes
               repeat ($urandom_range(1, 8))
                  push_byte(action_type'($urandom_range(0, 3)), byte_type'($urandom), 1'b1);
            end
         end
      end

      drain(3);
      if (mismatches == 0 && open_spans == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: sim.f
rtl/trsd_pkg.sv
rtl/trsd_req_if.sv
rtl/trsd_rsp_if.sv
rtl/text_rle_span_decoder_unit.sv
tb/trsd_span_checker.sv
tb/tb_top.sv
